// ===== rtl/tap_tempo_clock_generator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tap tempo clock generator
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_CLOCK_GENERATOR_TOP_DEFINES_SVH
`define TAP_TEMPO_CLOCK_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TTCG_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ttcg assertion failed");
`define TTCG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttcg implication failed");
`define TTCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcg next-cycle check failed");
`else
`define TTCG_ASSERT(lbl, expr)
`define TTCG_ASSERT_IMPL(lbl, ante, cons)
`define TTCG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ttcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttcg_pkg
// Shared widths, reset values, register indexes and divider status type.
// ----------------------------------------------------------------------------
package ttcg_pkg;

  localparam int TICKS_W      = 7;
  localparam int BEAT_W       = 24;
  localparam int PERIOD_OUT_W = 24;
  localparam int CFG_IDX_W    = 3;
  // result word: clock pulse, tap taken, led, period
  localparam int RES_W        = 3 + PERIOD_OUT_W;

  // divider lanes
  localparam int LANES        = 3;
  localparam int LANE_SINCE   = 0;
  localparam int LANE_SLOWEST = 1;
  localparam int LANE_FASTEST = 2;

  // register reset values
  localparam logic [TICKS_W-1:0] RST_TICKS_PER_TAP = 7'd24;
  localparam logic [BEAT_W-1:0]  RST_INITIAL_BEAT  = 24'd500000;
  localparam logic [BEAT_W-1:0]  RST_SLOWEST_BEAT  = 24'd1500000;
  localparam logic [BEAT_W-1:0]  RST_FASTEST_BEAT  = 24'd250000;
  localparam logic [BEAT_W-1:0]  RST_DEBOUNCE      = 24'd240000;
  localparam logic [BEAT_W-1:0]  RST_LED_WINDOW    = 24'd200000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS_PER_TAP = 3'd0,
    REG_INITIAL_BEAT  = 3'd1,
    REG_SLOWEST_BEAT  = 3'd2,
    REG_FASTEST_BEAT  = 3'd3,
    REG_DEBOUNCE      = 3'd4,
    REG_LED_WINDOW    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/ttcg_fifo.sv =====
`timescale 1ns / 1ps
`include "tap_tempo_clock_generator_top_defines.svh"
// ----------------------------------------------------------------------------
// ttcg_fifo
// Small register queue; push is dropped when full, pop ignored when empty.
// ----------------------------------------------------------------------------
module ttcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // store incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `TTCG_ASSERT(a_fifo_cnt_bound, cnt_r <= CNT_W'(DEPTH))

endmodule

// ===== rtl/ttcg_div.sv =====
`timescale 1ns / 1ps
`include "tap_tempo_clock_generator_top_defines.svh"
// ----------------------------------------------------------------------------
// ttcg_div
// Restoring divider, one quotient bit per cycle, several dividends by one
// shared narrow divisor.
// ----------------------------------------------------------------------------
module ttcg_div #(
  parameter int DW = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ttcg_pkg::TICKS_W-1:0] divisor,
  input  logic [DW-1:0]                dividend [ttcg_pkg::LANES],
  output ttcg_pkg::div_stat_t          status,
  output logic [DW-1:0]                quotient [ttcg_pkg::LANES]
);

  import ttcg_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [TICKS_W-1:0] dvsr_r;
  logic [TICKS_W-1:0] rem_r  [LANES];
  logic [DW-1:0]      num_r  [LANES];
  logic [TICKS_W:0]   rem_sh [LANES];
  logic [TICKS_W:0]   rem_nx [LANES];
  logic               q_bit  [LANES];
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  // one shift-subtract step on every lane
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l] = {rem_r[l], num_r[l][DW-1]};
      q_bit[l]  = (rem_sh[l] >= {1'b0, dvsr_r});
      rem_nx[l] = q_bit[l] ? (rem_sh[l] - {1'b0, dvsr_r}) : rem_sh[l];
    end
  end

  // load operands, iterate, flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr_r <= divisor;
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= '0;
        num_r[l] <= dividend[l];
      end
    end else if (busy_r) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[l] <= rem_nx[l][TICKS_W-1:0];
        num_r[l] <= {num_r[l][DW-2:0], q_bit[l]};
      end
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = num_r;

  `TTCG_ASSERT_IMPL(a_div_start_idle, start, !busy_r)

endmodule

// ===== rtl/ttcg_front.sv =====
`timescale 1ns / 1ps
`include "tap_tempo_clock_generator_top_defines.svh"
// ----------------------------------------------------------------------------
// ttcg_front
// Tick intake: tracks time since the last tap, debounces the switch and
// decides the LED level, then hands a tick word to the back end.
// ----------------------------------------------------------------------------
module ttcg_front #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        switch_down,
  input  logic [ttcg_pkg::BEAT_W-1:0] debounce_us,
  input  logic [ttcg_pkg::BEAT_W-1:0] led_window_us,
  input  logic                        mid_full,
  output logic                        mid_push,
  output logic [TIME_WIDTH+1:0]       mid_data
);

  import ttcg_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int DW = (TW > BEAT_W) ? TW : BEAT_W;
  localparam logic [TW-1:0] TMAX = '1;
  localparam longint unsigned TMAX_L = (64'd1 << TW) - 64'd1;
  localparam longint unsigned RST_SINCE_L = 64'(RST_INITIAL_BEAT);
  localparam logic [TW-1:0] RST_SINCE =
    TW'((RST_SINCE_L > TMAX_L) ? TMAX_L : RST_SINCE_L);

  logic [TW-1:0] since_r;
  logic [TW-1:0] since_nxt;
  logic [TW-1:0] since_inc;
  logic          tap;
  logic          led;

  // saturating tick count, debounced tap test, LED window
  assign since_inc = (since_r == TMAX) ? since_r : since_r + TW'(1);
  assign tap       = switch_down && (DW'(since_inc) > DW'(debounce_us));
  assign since_nxt = tap ? '0 : since_inc;
  assign led       = (DW'(since_nxt) < DW'(led_window_us));

  assign mid_push = push && !mid_full;
  assign mid_data = {tap, led, since_inc};

  // hold elapsed time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= RST_SINCE;
    end else if (mid_push) begin
      since_r <= since_nxt;
    end
  end

  `TTCG_ASSERT_NEXT(a_front_tap_clears, mid_push && tap, since_r == '0)

endmodule

// ===== rtl/ttcg_back.sv =====
`timescale 1ns / 1ps
`include "tap_tempo_clock_generator_top_defines.svh"
// ----------------------------------------------------------------------------
// ttcg_back
// Execution side: runs the pulse countdown, and on a tap divides and clamps
// the new period before writing the result word.
// ----------------------------------------------------------------------------
module ttcg_back #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mid_empty,
  input  logic [TIME_WIDTH+1:0]        mid_data,
  output logic                         mid_pop,
  input  logic [ttcg_pkg::TICKS_W-1:0] ticks_per_tap,
  input  logic [ttcg_pkg::BEAT_W-1:0]  slowest_beat_us,
  input  logic [ttcg_pkg::BEAT_W-1:0]  fastest_beat_us,
  input  logic                         out_full,
  output logic                         out_push,
  output logic [ttcg_pkg::RES_W-1:0]   out_data
);

  import ttcg_pkg::*;

  localparam int TW = TIME_WIDTH;
  localparam int DW = (TW > BEAT_W) ? TW : BEAT_W;
  localparam logic [TW-1:0] TMAX = '1;
  localparam longint unsigned TMAX_L = (64'd1 << TW) - 64'd1;
  localparam longint unsigned RST_P_L =
    64'(RST_INITIAL_BEAT) / 64'(RST_TICKS_PER_TAP);
  localparam logic [TW-1:0] RST_PERIOD = TW'((RST_P_L > TMAX_L) ? TMAX_L : RST_P_L);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t             state_r, state_nxt;
  logic [TW-1:0]      cnt_r, cnt_nxt;
  logic [TW-1:0]      period_r, period_nxt;
  logic               pulse_r, pulse_nxt;
  logic               led_r, led_nxt;

  logic               rec_tap;
  logic               rec_led;
  logic [TW-1:0]      rec_since;
  logic               pulse_now;
  logic [TW-1:0]      reload;
  logic [TICKS_W-1:0] ticks_eff;
  logic               div_start;
  div_stat_t          div_st;
  logic [DW-1:0]      dividend [LANES];
  logic [DW-1:0]      quot     [LANES];
  logic [TW-1:0]      cand, hi, lo, p_keep, p_hi, p_new;
  logic [TW:0]        limit;

  // unpack tick word
  assign rec_tap   = mid_data[TW+1];
  assign rec_led   = mid_data[TW];
  assign rec_since = mid_data[TW-1:0];

  // countdown reload from the current period
  assign pulse_now = (cnt_r == '0);
  assign reload    = (period_r == '0) ? '0 : period_r - TW'(1);

  // divider operands
  assign ticks_eff              = (ticks_per_tap == '0) ? TICKS_W'(1) : ticks_per_tap;
  assign dividend[LANE_SINCE]   = DW'(rec_since);
  assign dividend[LANE_SLOWEST] = DW'(slowest_beat_us);
  assign dividend[LANE_FASTEST] = DW'(fastest_beat_us);

  ttcg_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (ticks_eff),
    .dividend (dividend),
    .status   (div_st),
    .quotient (quot)
  );

  // missed-tap filter, then slowest and fastest clamps
  assign cand   = TW'(quot[LANE_SINCE]);
  assign hi     = (quot[LANE_SLOWEST] > DW'(TMAX)) ? TMAX : TW'(quot[LANE_SLOWEST]);
  assign lo     = (quot[LANE_FASTEST] > DW'(TMAX)) ? TMAX : TW'(quot[LANE_FASTEST]);
  assign limit  = (TW+1)'(period_r) + (TW+1)'(period_r >> 1) + (TW+1)'(period_r >> 2);
  assign p_keep = ((TW+1)'(cand) < limit) ? cand : period_r;
  assign p_hi   = (p_keep > hi) ? hi : p_keep;
  assign p_new  = (p_hi < lo) ? lo : p_hi;

  // sequence one tick word at a time
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    pulse_nxt  = pulse_r;
    led_nxt    = led_r;
    mid_pop    = 1'b0;
    out_push   = 1'b0;
    div_start  = 1'b0;
    out_data   = {pulse_r, 1'b1, led_r, PERIOD_OUT_W'(p_new)};
    case (state_r)
      ST_IDLE: begin
        if (!mid_empty && !out_full) begin
          mid_pop   = 1'b1;
          pulse_nxt = pulse_now;
          cnt_nxt   = pulse_now ? reload : cnt_r - TW'(1);
          if (rec_tap) begin
            div_start = 1'b1;
            led_nxt   = rec_led;
            state_nxt = ST_DIV;
          end else begin
            out_push = 1'b1;
            out_data = {pulse_now, 1'b0, rec_led, PERIOD_OUT_W'(period_r)};
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          out_push   = 1'b1;
          period_nxt = p_new;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold state and period
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      period_r <= RST_PERIOD;
      pulse_r  <= 1'b0;
      led_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
      pulse_r  <= pulse_nxt;
      led_r    <= led_nxt;
    end
  end

  `TTCG_ASSERT_IMPL(a_back_out_room, out_push, !out_full)
  `TTCG_ASSERT_NEXT(a_back_div_wait, div_start, state_r == ST_DIV && div_st.busy)
  `TTCG_ASSERT_NEXT(a_back_period_hold, !(state_r == ST_DIV && div_st.done), $stable(period_r))

endmodule

// ===== rtl/tap_tempo_clock_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_tempo_clock_generator_top
// Tap tempo clock: one word per microsecond tick in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//  Input queue: present in_switch_down with push; the word is taken when
//  full is low. Send one word per microsecond tick.
//  Result queue: while empty is low the oldest result sits on the out_ ports;
//  pop takes it. Every input word gives exactly one result word.
//  Config: cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//  Write only while no word is in flight.
// Timing:
//  A word without a tap passes from the input queue through the back end into the
//  result queue; such words flow at one per cycle while the result queue has room
//  and no tap word is in the back end. A tap word holds the back end while the
//  bit-serial divider forms the new period and both clamp limits. Input words
//  keep queuing meanwhile until full rises.
// Reset: registers take their default values, the elapsed time restarts
//  from the default initial beat and the first word emits a pulse.
// Stall: while pop stays low results queue up, then full rises and input
//  stops; nothing is dropped.
// ----------------------------------------------------------------------------
module tap_tempo_clock_generator_top #(
  parameter int TIME_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input queue
  input  logic                             push,
  output logic                             full,
  input  logic                             in_switch_down,
  // result queue
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_clock_pulse,
  output logic                             out_tap_taken,
  output logic                             out_led_lit,
  output logic [ttcg_pkg::PERIOD_OUT_W-1:0] out_clock_period_us,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcg_pkg::BEAT_W-1:0]      cfg_data
);

  import ttcg_pkg::*;

  localparam int MID_W = TIME_WIDTH + 2;

  logic [TICKS_W-1:0] ticks_r;
  logic [BEAT_W-1:0]  slowest_r;
  logic [BEAT_W-1:0]  fastest_r;
  logic [BEAT_W-1:0]  debounce_r;
  logic [BEAT_W-1:0]  led_win_r;

  logic               mid_push;
  logic [MID_W-1:0]   mid_wdata;
  logic               mid_full;
  logic               mid_pop;
  logic [MID_W-1:0]   mid_rdata;
  logic               mid_empty;
  logic               res_push;
  logic [RES_W-1:0]   res_wdata;
  logic               res_full;
  logic [RES_W-1:0]   res_rdata;

  assign cfg_ready = 1'b1;

  // register file; initial beat only shapes the reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= RST_TICKS_PER_TAP;
      slowest_r  <= RST_SLOWEST_BEAT;
      fastest_r  <= RST_FASTEST_BEAT;
      debounce_r <= RST_DEBOUNCE;
      led_win_r  <= RST_LED_WINDOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICKS_PER_TAP: ticks_r    <= cfg_data[TICKS_W-1:0];
        REG_INITIAL_BEAT:  ticks_r    <= ticks_r;
        REG_SLOWEST_BEAT:  slowest_r  <= cfg_data;
        REG_FASTEST_BEAT:  fastest_r  <= cfg_data;
        REG_DEBOUNCE:      debounce_r <= cfg_data;
        REG_LED_WINDOW:    led_win_r  <= cfg_data;
        default:           ticks_r    <= ticks_r;
      endcase
    end
  end

  assign full = mid_full;

  ttcg_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .switch_down   (in_switch_down),
    .debounce_us   (debounce_r),
    .led_window_us (led_win_r),
    .mid_full      (mid_full),
    .mid_push      (mid_push),
    .mid_data      (mid_wdata)
  );

  ttcg_fifo #(
    .WIDTH (MID_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  ttcg_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mid_empty       (mid_empty),
    .mid_data        (mid_rdata),
    .mid_pop         (mid_pop),
    .ticks_per_tap   (ticks_r),
    .slowest_beat_us (slowest_r),
    .fastest_beat_us (fastest_r),
    .out_full        (res_full),
    .out_push        (res_push),
    .out_data        (res_wdata)
  );

  ttcg_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  // split result word
  assign out_clock_pulse     = res_rdata[RES_W-1];
  assign out_tap_taken       = res_rdata[RES_W-2];
  assign out_led_lit         = res_rdata[RES_W-3];
  assign out_clock_period_us = res_rdata[PERIOD_OUT_W-1:0];

endmodule
